// File: sv/aes_pkg.sv
package aes_pkg;

    localparam int ScheduleWords = 60;
    localparam int KeyIdxW = 6;
    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] REG_KEY0   = 3'd0;
    localparam logic [RegIdxW-1:0] REG_KEY1   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_KEY2   = 3'd2;
    localparam logic [RegIdxW-1:0] REG_KEY3   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_KEYLEN = 3'd4;

    typedef struct packed {
        logic load;
        logic dec;
        logic first_round;
        logic last_round;
        logic capture;
    } aes_cmd_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    // x^254 by square and multiply (254 = 8'b1111_1110)
    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        r = 8'h01;
        base = x;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, base);
            base = gmul(base, base);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        rotl8 = (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = ginv(x);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
        inv_sbox_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] sbox_arr_t [256];

    function automatic sbox_arr_t mk_sbox(input logic inv);
        sbox_arr_t t;
        for (int i = 0; i < 256; i++)
            t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        mk_sbox = t;
    endfunction

    localparam sbox_arr_t SBOX = mk_sbox(1'b0);
    localparam sbox_arr_t INV_SBOX = mk_sbox(1'b1);

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: sv/aes_keysched.sv
module aes_keysched
    import aes_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [3:0]          nk,
    input  logic [255:0]        key,
    input  logic [KeyIdxW-1:0]  rd_addr,
    output logic [31:0]         rd_data,
    output logic                busy
);
    logic [31:0]         mem [ScheduleWords];
    logic [KeyIdxW-1:0]  idx_reg, idx_next, total;
    logic [3:0]          phase_reg, phase_next;
    logic [7:0]          rc_reg, rc_next;
    logic [31:0]         prev_reg, back_reg;
    logic                run_reg, run_next;
    logic                step_reg;
    logic [31:0]         t, w, kw;
    logic [KeyIdxW-1:0]  ra;

    assign total = KeyIdxW'(4 * (nk + 7));
    assign busy  = run_reg | start;
    assign kw    = key[255 - 32*idx_reg[2:0] -: 32];

    always_comb begin
        t = prev_reg;
        if (phase_reg == 4'd0)
            t = sub_word({prev_reg[23:0], prev_reg[31:24]}) ^ {rc_reg, 24'h0};
        else if (nk > 4'd6 && phase_reg == 4'd4)
            t = sub_word(prev_reg);
        w = (idx_reg < KeyIdxW'(nk)) ? kw : (back_reg ^ t);
    end

    // each word: read w[i-nk] first, then write w[i]
    always_comb begin
        run_next = run_reg;
        idx_next = idx_reg;
        phase_next = phase_reg;
        rc_next = rc_reg;
        if (start) begin
            run_next = 1'b1;
            idx_next = '0;
            phase_next = 4'd0;
            rc_next = 8'h8d;
        end else if (run_reg && step_reg) begin
            idx_next = idx_reg + 1'b1;
            if (phase_reg == nk - 4'd1) begin
                phase_next = 4'd0;
                rc_next = xtime(rc_reg);
            end else begin
                phase_next = phase_reg + 4'd1;
            end
            if (idx_reg + 1'b1 == total) run_next = 1'b0;
        end
    end

    assign ra = (run_reg && idx_reg >= KeyIdxW'(nk)) ? (idx_reg - KeyIdxW'(nk)) : rd_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            step_reg <= 1'b0;
            idx_reg <= '0;
            phase_reg <= 4'd0;
            rc_reg <= 8'h00;
        end else begin
            run_reg <= run_next;
            idx_reg <= idx_next;
            phase_reg <= phase_next;
            rc_reg <= rc_next;
            step_reg <= start ? 1'b0 : (run_reg ? ~step_reg : 1'b0);
            if (!start && run_reg && step_reg) begin
                mem[idx_reg] <= w;
                prev_reg <= w;
            end
        end
        back_reg <= mem[ra];
        rd_data <= mem[rd_addr];
    end
endmodule

// File: sv/aes_datapath.sv
module aes_datapath
    import aes_pkg::*;
(
    input  logic          aclk,
    input  aes_cmd_t      cmd,
    input  logic [127:0]  blk_in,
    input  logic [127:0]  round_key,
    output logic [127:0]  result
);
    logic [127:0] st_reg, st_next, ss, mx;

    function automatic logic [31:0] mixcol(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++) a[k] = c[31 - 8*k -: 8];
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else m = '{8'd2, 8'd3, 8'd1, 8'd1};
        o = '0;
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++)
                o[31 - 8*r -: 8] = o[31 - 8*r -: 8] ^ gmul(a[k], m[(k - r) & 3]);
        mixcol = o;
    endfunction

    always_comb begin
        ss = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (cmd.dec)
                    ss[127 - 8*(4*((c + r) & 3) + r) -: 8] =
                        INV_SBOX[st_reg[127 - 8*(4*c + r) -: 8]];
                else
                    ss[127 - 8*(4*c + r) -: 8] =
                        SBOX[st_reg[127 - 8*(4*((c + r) & 3) + r) -: 8]];
            end
        mx = ss;
        if (cmd.first_round) begin
            st_next = blk_in ^ round_key;
        end else if (cmd.dec) begin
            mx = ss ^ round_key;
            if (!cmd.last_round)
                for (int c = 0; c < 4; c++) mx[127 - 32*c -: 32] = mixcol(mx[127 - 32*c -: 32], 1'b1);
            st_next = mx;
        end else begin
            if (!cmd.last_round)
                for (int c = 0; c < 4; c++) mx[127 - 32*c -: 32] = mixcol(mx[127 - 32*c -: 32], 1'b0);
            st_next = mx ^ round_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) st_reg <= st_next;
        if (cmd.capture) result <= st_reg;
    end
endmodule

// File: sv/aes_ctrl.sv
module aes_ctrl
    import aes_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               in_dec,
    input  logic               cfg_we,
    input  logic [3:0]         nk,
    input  logic               ks_busy,
    input  logic               out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output logic               ks_start,
    output logic [KeyIdxW-1:0] rk_addr,
    output logic               rk_load,
    output logic [1:0]         rk_slot,
    output aes_cmd_t           cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_KEYS = 5'b00010, S_ADDR = 5'b00100,
        S_ROUND = 5'b01000, S_DONE = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic        valid_reg, valid_next, sched_reg, sched_next, dec_reg;
    logic        first_reg, first_next, cap;
    logic [3:0]  rnd_reg, rnd_next, nr;
    logic [2:0]  wcnt_reg, wcnt_next;
    logic        rk_load_reg;
    logic [1:0]  rk_slot_reg;

    assign nr = nk + 4'd6;
    assign in_ready = (state_reg == S_IDLE) && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    // one round-key word per cycle in S_ADDR; store data arrives in the following cycle
    assign rk_addr = KeyIdxW'({rnd_reg, wcnt_reg[1:0]});
    assign rk_load = rk_load_reg;
    assign rk_slot = rk_slot_reg;

    always_comb begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        first_next = first_reg;
        sched_next = sched_reg;
        wcnt_next = wcnt_reg;
        ks_start = 1'b0;
        cap = 1'b0;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin
                if (!sched_reg) begin
                    ks_start = 1'b1;
                    sched_next = 1'b1;
                    state_next = S_KEYS;
                end else state_next = S_ADDR;
                rnd_next = in_dec ? nr : 4'd0;
                first_next = 1'b1;
            end
            S_KEYS: if (!ks_busy) state_next = S_ADDR;
            S_ADDR: begin
                if (wcnt_reg == 3'd4) begin
                    wcnt_next = 3'd0;
                    state_next = S_ROUND;
                end else begin
                    wcnt_next = wcnt_reg + 3'd1;
                end
            end
            S_ROUND: begin
                first_next = 1'b0;
                if ((dec_reg && rnd_reg == 4'd0) || (!dec_reg && rnd_reg == nr))
                    state_next = S_DONE;
                else begin
                    rnd_next = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    state_next = S_ADDR;
                end
            end
            S_DONE: begin
                cap = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_we) sched_next = 1'b0;
        valid_next = cap ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        cmd.load = (state_reg == S_ROUND);
        cmd.dec = dec_reg;
        cmd.first_round = first_reg;
        cmd.last_round = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == nr);
        cmd.capture = cap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            sched_reg <= 1'b0;
            rnd_reg <= 4'd0;
            first_reg <= 1'b0;
            dec_reg <= 1'b0;
            wcnt_reg <= 3'd0;
            rk_load_reg <= 1'b0;
            rk_slot_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            sched_reg <= sched_next;
            rnd_reg <= rnd_next;
            first_reg <= first_next;
            wcnt_reg <= wcnt_next;
            rk_load_reg <= (state_reg == S_ADDR) && (wcnt_reg != 3'd4);
            rk_slot_reg <= wcnt_reg[1:0];
            if (in_fire) dec_reg <= in_dec;
        end
    end
endmodule

// File: sv/aes_block_cipher_unit.sv
// AES block cipher, ECB, 128/192/256-bit keys.
// Config: cfg_we/cfg_addr/cfg_wdata write key words 0..3 (index 0..3) and
//   key length (index 4: 0=128, 1=192, 2 or 3=256). Write only while idle.
// Input: s_tdata {block_low, block_high} (lowest bits first), s_tuser = cmd
//   (0 encrypt, 1 decrypt). One block at a time.
// Output: m_tdata {result_low, result_high}.
// Operation: Nr+1 passes through the single round unit (Nr = 10/12/14):
//   each pass reads its four round-key words from the store one per cycle
//   through the registered read port, then runs the round; the result is
//   then captured in the output register.
// The first block after reset or any config write to index 0..4 also
//   expands the key schedule first, reading and then writing each word.
// Overlap: no block is taken while one is in flight; the next block can be
//   taken in the same cycle the result is transferred.
// Reset clears the control and invalidates the schedule.
// Stall: a result waits in the output register and no block is taken
//   until it is transferred.
module aes_block_cipher_unit
    import aes_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [63:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,  // block_high[63:0], block_low[127:64]
    input  logic          s_tuser,  // cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata   // result_high[63:0], result_low[127:64]
);
    logic [63:0]         key_reg [4];
    logic [1:0]          klen_reg;
    logic [3:0]          nk;
    logic                ks_start, ks_busy, in_fire;
    logic [KeyIdxW-1:0]  rk_addr;
    logic                rk_load;
    logic [1:0]          rk_slot;
    logic [31:0]         rd_data;
    logic [127:0]        rk_reg, blk_reg, res;
    aes_cmd_t            cmd;

    assign nk = (klen_reg == 2'd0) ? 4'd4 : (klen_reg == 2'd1) ? 4'd6 : 4'd8;
    assign in_fire = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            klen_reg <= 2'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_KEY0: key_reg[0] <= cfg_wdata;
                REG_KEY1: key_reg[1] <= cfg_wdata;
                REG_KEY2: key_reg[2] <= cfg_wdata;
                REG_KEY3: key_reg[3] <= cfg_wdata;
                REG_KEYLEN: klen_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    logic ctrl_cfg;
    assign ctrl_cfg = cfg_we && (cfg_addr <= REG_KEYLEN);

    aes_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .in_dec(s_tuser), .cfg_we(ctrl_cfg), .nk,
        .ks_busy, .out_ready(m_tready), .in_ready(s_tready), .out_valid(m_tvalid),
        .ks_start, .rk_addr, .rk_load, .rk_slot, .cmd
    );

    aes_keysched u_ks (
        .aclk, .aresetn, .start(ks_start), .nk,
        .key({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .rd_addr(rk_addr), .rd_data, .busy(ks_busy)
    );

    // round key assembled one store word at a time
    always_ff @(posedge aclk) begin
        if (in_fire) blk_reg <= {s_tdata[63:0], s_tdata[127:64]};
        if (rk_load) rk_reg[127 - 32*rk_slot -: 32] <= rd_data;
    end

    aes_datapath u_dp (.aclk, .cmd, .blk_in(blk_reg), .round_key(rk_reg), .result(res));

    assign m_tdata = {res[63:0], res[127:64]};
endmodule

// File: sv/aes_checker.sv
module aes_checker (
    input logic aclk, input logic aresetn,
    input logic s_tvalid, input logic s_tready,
    input logic m_tvalid, input logic m_tready, input logic [127:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("held");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid || m_tready || $past(m_tvalid)) else $error("gap");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("busy");
endmodule

bind aes_block_cipher_unit aes_checker u_chk (.*);

// File: dv/tb_aes_block_cipher_unit.sv
module tb_aes_block_cipher_unit;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] res_lo;
        logic [63:0] res_hi;
    } aes_block_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [2:0]    cfg_addr;
    logic [63:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [127:0]  m_tdata;

    aes_block_cipher_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [63:0] key_word [4];
    logic [1:0]  key_len;
    logic [7:0]  fwd_sub [256];
    logic [7:0]  inv_sub [256];
    logic [31:0] sched [ScheduleWords];
    logic [7:0]  st [16];

    aes_block_t  expected_q [$];
    int          err_count;
    bit          stall_en;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_aes_block_cipher_unit: FAIL");
        $finish;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic void build_sub_tables();
        logic [7:0] recip;
        logic [7:0] y;
        for (int x = 0; x < 256; x++) begin
            recip = 8'h00;
            for (int c = 1; c < 256; c++)
                if (gf_mul(8'(x), 8'(c)) == 8'h01) recip = 8'(c);
            y = recip ^ rot8(recip, 1) ^ rot8(recip, 2) ^ rot8(recip, 3)
                ^ rot8(recip, 4) ^ 8'h63;
            fwd_sub[x] = y;
            inv_sub[y] = 8'(x);
        end
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    function automatic int key_words_now();
        return (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
    endfunction

    function automatic void expand_key(input int nk);
        logic [31:0] t;
        logic [7:0]  rc;
        int total;
        total = 4 * (nk + 7);
        for (int i = 0; i < nk; i++)
            sched[i] = (i % 2) ? key_word[i / 2][31:0] : key_word[i / 2][63:32];
        for (int i = nk; i < total; i++) begin
            t = sched[i - 1];
            if (i % nk == 0) begin
                rc = 8'h8d;
                for (int k = 0; k < i / nk; k++) rc = gf_dbl(rc);
                t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            end else if (nk > 6 && i % nk == 4) begin
                t = subst_word(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
    endfunction

    function automatic void add_key(input int rnd);
        logic [31:0] w;
        for (int c = 0; c < 4; c++) begin
            w = sched[(4 * rnd + c) % ScheduleWords];
            st[4*c]   ^= w[31:24];
            st[4*c+1] ^= w[23:16];
            st[4*c+2] ^= w[15:8];
            st[4*c+3] ^= w[7:0];
        end
    endfunction

    function automatic void sub_shift_rows(input bit inverse);
        logic [7:0] t [16];
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = 4 * ((c + r) % 4) + r;
                if (inverse) t[src] = inv_sub[st[4*c+r]];
                else t[4*c+r] = fwd_sub[st[src]];
            end
        st = t;
    endfunction

    function automatic void mix_cols(input bit inverse);
        logic [7:0] coef [4];
        logic [7:0] t [4];
        if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r] = 8'h00;
                for (int k = 0; k < 4; k++)
                    t[r] ^= gf_mul(st[4*c+k], coef[(k - r + 4) % 4]);
            end
            for (int r = 0; r < 4; r++) st[4*c+r] = t[r];
        end
    endfunction

    // schedule is rebuilt per block; key regs only change between phases
    function automatic aes_block_t cipher_block(input logic dec, input logic [63:0] hi,
                                                input logic [63:0] lo);
        aes_block_t res;
        int nk;
        int nr;
        nk = key_words_now();
        nr = nk + 6;
        expand_key(nk);
        for (int i = 0; i < 8; i++) begin
            st[i]     = hi[56-8*i +: 8];
            st[8 + i] = lo[56-8*i +: 8];
        end
        if (!dec) begin
            add_key(0);
            for (int r = 1; r < nr; r++) begin
                sub_shift_rows(1'b0);
                mix_cols(1'b0);
                add_key(r);
            end
            sub_shift_rows(1'b0);
            add_key(nr);
        end else begin
            add_key(nr);
            for (int r = nr - 1; r >= 1; r--) begin
                sub_shift_rows(1'b1);
                add_key(r);
                mix_cols(1'b1);
            end
            sub_shift_rows(1'b1);
            add_key(0);
        end
        for (int i = 0; i < 8; i++) begin
            res.res_hi[56-8*i +: 8] = st[i];
            res.res_lo[56-8*i +: 8] = st[8 + i];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch %s: got %h exp %h", what, got, exp_val);
        err_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        aes_block_t exp_blk;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[63:0], 64'h0);
            end else begin
                exp_blk = expected_q.pop_front();
                if (m_tdata[63:0] !== exp_blk.res_hi)
                    report_mismatch("result_high", m_tdata[63:0], exp_blk.res_hi);
                if (m_tdata[127:64] !== exp_blk.res_lo)
                    report_mismatch("result_low", m_tdata[127:64], exp_blk.res_lo);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= stall_en ? ($urandom_range(0, 99) >= 10) : 1'b1;
    end

    task automatic send_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo);
        @(negedge aclk);
        if (stall_en && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= dec;
        s_tdata  <= {lo, hi};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        expected_q.push_back(cipher_block(dec, hi, lo));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx < REG_KEYLEN) key_word[idx] = val;
        else if (idx == REG_KEYLEN) key_len = val[1:0];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        cfg_write(REG_KEY0, k0);
        cfg_write(REG_KEY1, k1);
        cfg_write(REG_KEY2, k2);
        cfg_write(REG_KEY3, k3);
        cfg_write(REG_KEYLEN, {62'h0, len});
    endtask

    task automatic test_field_extremes();
        logic [63:0] kpat;
        for (int len = 0; len < 4; len++) begin
            kpat = (len % 2) ? 64'hffff_ffff_ffff_ffff : 64'h0;
            load_key(2'(len), kpat, ~kpat, kpat, ~kpat);
            send_block(1'b0, 64'h0, 64'h0);
            send_block(1'b1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
            send_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
            send_block(1'b1, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
            drain();
        end
    endtask

    task automatic test_standard_keys();
        load_key(2'd0, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 64'h0, 64'h0);
        send_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        drain();
        cfg_write(REG_KEYLEN, 64'd1);
        cfg_write(REG_KEY2, 64'h1011_1213_1415_1617);
        send_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        drain();
        cfg_write(REG_KEYLEN, 64'd2);
        cfg_write(REG_KEY3, 64'h1819_1a1b_1c1d_1e1f);
        send_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_block(1'b1, 64'h8ea2_b7ca_5167_45bf, 64'heafc_4990_4b49_6089);
        drain();
        // unmapped indexes must leave the key untouched
        cfg_write(3'd5, rand64());
        cfg_write(3'd6, rand64());
        cfg_write(3'd7, rand64());
        send_block(1'b1, 64'h8ea2_b7ca_5167_45bf, 64'heafc_4990_4b49_6089);
        drain();
    endtask

    task automatic test_random_blocks();
        for (int ph = 0; ph < 8; ph++) begin
            load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            stall_en = (ph != 3);
            for (int n = 0; n < 50; n++) begin
                send_block(1'($urandom_range(0, 1)), rand64(), rand64());
                if (ph == 5 && n == 25) drain();
            end
            drain();
        end
        stall_en = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        stall_en  = 1'b1;
        err_count = 0;
        key_word  = '{default: 64'h0};
        key_len   = 2'd0;
        build_sub_tables();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_field_extremes();
        test_standard_keys();
        test_random_blocks();
        drain();

        if (err_count == 0 && expected_q.size() == 0) begin
            $display("tb_aes_block_cipher_unit: PASS");
        end else begin
            $display("tb_aes_block_cipher_unit: FAIL");
        end
        $finish;
    end

endmodule
